@@ hw/rtl/hic_pkg.sv @@
`default_nettype none

package hic_pkg;

	localparam int unsigned MAX_LEVELS = 16;
	localparam int unsigned COORD_W    = 16;
	localparam int unsigned INDEX_W    = 2 * MAX_LEVELS;

	// Word data carried down the cell chain alongside the valid bit
	typedef struct packed {
		logic               transpose;
		logic               invert;
		logic [COORD_W-1:0] zw;
		logic [COORD_W-1:0] yw;
		logic [COORD_W-1:0] first;
		logic [COORD_W-1:0] second;
	} flow_t;

endpackage

`default_nettype wire

@@ hw/rtl/hilbert_index_to_coords.sv @@
// Channel   | Signals                        | Handshake
// ----------+--------------------------------+------------------------------------
// index in  | curve_index                    | taken when start high, busy low
// coord out | coord_first, coord_second      | one cycle, marked by done
//
// One index is taken every cycle; busy never rises.
// Each index passes through a chain of LEVELS registered cells, one curve level per cell,
// so done rises when the index leaves the last cell.
// Reset clears only the valid bits of the chain; data registers are not reset.
// The receiver cannot stall, so results leave the chain as soon as they arrive.
`default_nettype none

module hilbert_index_to_coords #(
	parameter int unsigned LEVELS = hic_pkg::MAX_LEVELS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [hic_pkg::INDEX_W-1:0]  curve_index,
	output logic                              done,
	output logic [hic_pkg::COORD_W-1:0]       coord_first,
	output logic [hic_pkg::COORD_W-1:0]       coord_second
);

	import hic_pkg::*;

	// unused upper levels see Z and Y clear: transpose toggles once per level
	localparam bit INIT_TRANSPOSE = (((MAX_LEVELS - LEVELS) % 2) == 0);

	logic               valid_c [0:LEVELS];
	flow_t              flow_c  [0:LEVELS];
	logic [COORD_W-1:0] xw;
	logic [COORD_W-1:0] yw;

	always_comb begin
		for (int i = 0; i < MAX_LEVELS; i++) begin
			xw[i] = curve_index[2*i];
			yw[i] = curve_index[2*i+1];
		end
	end

	assign busy = 1'b0;

	always_comb begin
		valid_c[0]          = start & ~busy;
		flow_c[0].transpose = INIT_TRANSPOSE;
		flow_c[0].invert    = 1'b0;
		flow_c[0].zw        = xw ^ yw;
		flow_c[0].yw        = yw;
		flow_c[0].first     = '0;
		flow_c[0].second    = '0;
	end

	for (genvar k = 0; k < LEVELS; k++) begin : g_cell
		hic_cell #(
			.LVL(LEVELS - 1 - k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (valid_c[k]),
			.flow_in  (flow_c[k]),
			.valid_out(valid_c[k+1]),
			.flow_out (flow_c[k+1])
		);
	end

	assign done         = valid_c[LEVELS];
	assign coord_first  = flow_c[LEVELS].first;
	assign coord_second = flow_c[LEVELS].second;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
	else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LEVELS done)
	else $error("result missing LEVELS cycles after start");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LEVELS))
	else $error("result without matching transaction");

	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((coord_first >> LEVELS) == '0) && ((coord_second >> LEVELS) == '0))
	else $error("coordinate beyond used levels");

endmodule

`default_nettype wire

@@ hw/rtl/hic_cell.sv @@
`default_nettype none

module hic_cell #(
	parameter int unsigned LVL = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid_in,
	input  hic_pkg::flow_t      flow_in,
	output logic                valid_out,
	output hic_pkg::flow_t      flow_out
);

	import hic_pkg::*;

	logic   zb;
	logic   yb;
	logic   a_bit;
	logic   b_bit;
	flow_t  flow_next;
	logic   valid_q;
	flow_t  flow_q;

	always_comb begin
		zb    = flow_in.zw[LVL];
		yb    = flow_in.yw[LVL];
		a_bit = (flow_in.transpose ? yb : zb) ^ flow_in.invert;
		b_bit = (flow_in.transpose ? zb : yb) ^ flow_in.invert;

		flow_next             = flow_in;
		flow_next.first[LVL]  = a_bit;
		flow_next.second[LVL] = b_bit;
		// a clear Z bit flips orientation; with Y set it also flips sense
		flow_next.transpose   = flow_in.transpose ^ ~zb;
		flow_next.invert      = flow_in.invert ^ (~zb & yb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		flow_q <= flow_next;
	end

	assign valid_out = valid_q;
	assign flow_out  = flow_q;

endmodule

`default_nettype wire
